// ----- hw/rtl/cha_pkg.sv -----
`default_nettype none

package cha_pkg;

   localparam int DATA_W    = 16;
   localparam int HEAD_W    = 13;
   localparam int CNT_W     = 3;
   localparam int STEP_W    = 5;
   localparam int SUM_W     = 19;
   localparam int SPAN_W    = 17;
   localparam int MAG_W     = 18;
   localparam int Q_FRAC    = 14;
   localparam int DVD_W     = 32;
   localparam int QUO_W     = 17;
   localparam int CXY_W     = 20;
   localparam int ANG_W     = 26;
   localparam int WRAP_W    = 15;
   localparam int RND_SHIFT = 12;
   localparam int CSR_IDX_W = 3;
   localparam int RCP_SHIFT = 21;
   localparam int RCP_W     = 22;

   localparam int SAMPLES_AVERAGED_DEF = 5;
   localparam int CORDIC_STEPS_DEF     = 16;
   localparam int ATAN_LEN             = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y = 3'd3;

   localparam logic signed [DATA_W-1:0] CAL_MIN_RST = 16'sh8000;
   localparam logic signed [DATA_W-1:0] CAL_MAX_RST = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] Q_SAT_POS   = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] Q_SAT_NEG   = 16'sh8000;
   localparam logic [QUO_W-1:0]         Q_LIM_POS   = 17'd32767;
   localparam logic [QUO_W-1:0]         Q_LIM_NEG   = 17'd32768;

   localparam logic signed [ANG_W-1:0]  DEG90      = 26'sd5898240;
   localparam logic signed [ANG_W-1:0]  ROUND_HALF = 26'sd2048;
   localparam logic signed [WRAP_W-1:0] FULL_TURN  = 15'sd5760;

   typedef enum logic [1:0] {
      SEL_AVG_X,
      SEL_AVG_Y,
      SEL_SCL_X,
      SEL_SCL_Y
   } sel_type;

   typedef struct packed {
      logic              acc;
      logic              last;
      logic              load_op;
      logic              div_start;
      sel_type           sel;
      logic              rot;
      logic              cord;
      logic [STEP_W-1:0] step;
      logic              fin;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic cal_err;
   } stat_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ANG_W-1:0] atan_angle(input logic [STEP_W-1:0] idx);
      logic [ANG_W-1:0] val;
      case (idx)
         5'd0:    val = ANG_W'(2949120);
         5'd1:    val = ANG_W'(1740967);
         5'd2:    val = ANG_W'(919879);
         5'd3:    val = ANG_W'(466945);
         5'd4:    val = ANG_W'(234379);
         5'd5:    val = ANG_W'(117304);
         5'd6:    val = ANG_W'(58666);
         5'd7:    val = ANG_W'(29335);
         5'd8:    val = ANG_W'(14668);
         5'd9:    val = ANG_W'(7334);
         5'd10:   val = ANG_W'(3667);
         5'd11:   val = ANG_W'(1833);
         5'd12:   val = ANG_W'(917);
         5'd13:   val = ANG_W'(458);
         5'd14:   val = ANG_W'(229);
         5'd15:   val = ANG_W'(115);
         5'd16:   val = ANG_W'(57);
         5'd17:   val = ANG_W'(29);
         5'd18:   val = ANG_W'(14);
         5'd19:   val = ANG_W'(7);
         5'd20:   val = ANG_W'(4);
         5'd21:   val = ANG_W'(2);
         5'd22:   val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cha_div.sv -----
`default_nettype none

module cha_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [cha_pkg::DVD_W-1:0]     dividend,
   input  wire logic [cha_pkg::DATA_W-1:0]    divisor,
   output logic                               done,
   output logic [cha_pkg::QUO_W-1:0]          quotient,
   output logic                               ovf
);

   localparam int DW = cha_pkg::DATA_W;
   localparam int QW = cha_pkg::QUO_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] dvd_ff, dvd_in;
   logic [DW-1:0] den_ff, den_in;
   logic          ovf_ff, ovf_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[QW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(QW);
         rem_in  = DW'(dividend[cha_pkg::DVD_W-1:QW]);
         dvd_in  = dividend[QW-1:0];
         den_in  = divisor;
         ovf_in  = DW'(dividend[cha_pkg::DVD_W-1:QW]) >= divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         dvd_in = {dvd_ff[QW-2:0], fits};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
   assign ovf      = ovf_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cha_dp.sv -----
`default_nettype none

module cha_dp #(
   parameter int SAMPLES_AVERAGED = cha_pkg::SAMPLES_AVERAGED_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [cha_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [cha_pkg::DATA_W-1:0]           csr_wdata,
   input  wire logic signed [cha_pkg::DATA_W-1:0]    req_mag_x,
   input  wire logic signed [cha_pkg::DATA_W-1:0]    req_mag_y,
   input  wire logic signed [cha_pkg::DATA_W-1:0]    req_mag_z,
   input  wire cha_pkg::cmd_type                     cmd,
   output cha_pkg::stat_type                         stat,
   output logic signed [cha_pkg::DATA_W-1:0]         rsp_avg_x,
   output logic signed [cha_pkg::DATA_W-1:0]         rsp_avg_y,
   output logic signed [cha_pkg::DATA_W-1:0]         rsp_last_z,
   output logic [cha_pkg::HEAD_W-1:0]                rsp_heading,
   output logic                                      rsp_cal_error
);

   localparam int DW  = cha_pkg::DATA_W;
   localparam int SW  = cha_pkg::SUM_W;
   localparam int PW  = cha_pkg::SPAN_W;
   localparam int MW  = cha_pkg::MAG_W;
   localparam int QF  = cha_pkg::Q_FRAC;
   localparam int VW  = cha_pkg::DVD_W;
   localparam int QW  = cha_pkg::QUO_W;
   localparam int CW  = cha_pkg::CXY_W;
   localparam int AW  = cha_pkg::ANG_W;
   localparam int WW  = cha_pkg::WRAP_W;
   localparam int HW  = cha_pkg::HEAD_W;
   localparam int RW  = cha_pkg::RCP_W;
   localparam int RS  = cha_pkg::RCP_SHIFT;
   localparam logic [DW-1:0] DIVISOR_AVG = DW'(SAMPLES_AVERAGED);
   localparam logic [RW-1:0] RECIP =
      RW'(((1 << RS) + SAMPLES_AVERAGED - 1) / SAMPLES_AVERAGED);

   logic signed [DW-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [DW-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic signed [SW-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [SW-1:0] tot_x_ff, tot_x_in, tot_y_ff, tot_y_in;
   logic signed [DW-1:0] zlat_ff, zlat_in;
   logic [VW-1:0]        op_mag_ff, op_mag_in;
   logic                 op_neg_ff, op_neg_in;
   logic [DW-1:0]        op_den_ff, op_den_in;
   logic signed [DW-1:0] avg_x_ff, avg_x_in, avg_y_ff, avg_y_in;
   logic signed [DW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AW-1:0] ang_ff, ang_in;
   logic                 zero_ff, zero_in;
   logic [HW-1:0]        head_ff, head_in;
   logic signed [DW-1:0] ravg_x_ff, ravg_x_in, ravg_y_ff, ravg_y_in, rz_ff, rz_in;
   logic [HW-1:0]        rhead_ff, rhead_in;
   logic                 rerr_ff, rerr_in;
   logic                 rcp_done_ff, rcp_done_in;
   logic [QW-1:0]        rcp_quo_ff, rcp_quo_in;

   logic signed [SW-1:0] ext_x, ext_y;
   logic signed [PW-1:0] span_x, span_y, diff_x, diff_y;
   logic signed [SW-1:0] num_x, num_y, op_num, op_abs;
   logic                 op_scaled;
   logic                 cal_err;
   logic                 div_done, div_ovf;
   logic                 div_go, quo_done;
   logic [MW+RW-1:0]     rcp_prod;
   logic [QW-1:0]        div_quo, quo, neg_quo;
   logic signed [DW-1:0] avg_val, scl_val;
   logic signed [CW-1:0] cx_w, cy_w, xs, ys;
   logic signed [AW-1:0] atan_s, ang_sum, ang_rnd;
   logic signed [WW-1:0] hd0, hd1, hd2;

   always_comb begin
      ext_x  = SW'(req_mag_x);
      ext_y  = SW'(req_mag_y);
      span_x = PW'(max_x_ff) - PW'(min_x_ff);
      span_y = PW'(max_y_ff) - PW'(min_y_ff);
      cal_err = span_x[PW-1] || (span_x == '0) || span_y[PW-1] || (span_y == '0);
      diff_x = PW'(avg_x_ff) - PW'(min_x_ff);
      diff_y = PW'(avg_y_ff) - PW'(min_y_ff);
      num_x  = {diff_x[PW-1], diff_x, 1'b0} - SW'(span_x);
      num_y  = {diff_y[PW-1], diff_y, 1'b0} - SW'(span_y);
   end

   // configuration
   always_comb begin
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      if (csr_we) begin
         case (csr_index)
            cha_pkg::CSR_MIN_X: min_x_in = csr_wdata;
            cha_pkg::CSR_MAX_X: max_x_in = csr_wdata;
            cha_pkg::CSR_MIN_Y: min_y_in = csr_wdata;
            cha_pkg::CSR_MAX_Y: max_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // accumulate
   always_comb begin
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      tot_x_in = tot_x_ff;
      tot_y_in = tot_y_ff;
      zlat_in  = zlat_ff;
      if (cmd.last) begin
         sum_x_in = '0;
         sum_y_in = '0;
         tot_x_in = sum_x_ff + ext_x;
         tot_y_in = sum_y_ff + ext_y;
         zlat_in  = req_mag_z;
      end else if (cmd.acc) begin
         sum_x_in = sum_x_ff + ext_x;
         sum_y_in = sum_y_ff + ext_y;
      end
   end

   // divider operands
   always_comb begin
      case (cmd.sel)
         cha_pkg::SEL_AVG_X: begin
            op_num = tot_x_ff; op_scaled = 1'b0; op_den_in = DIVISOR_AVG;
         end
         cha_pkg::SEL_AVG_Y: begin
            op_num = tot_y_ff; op_scaled = 1'b0; op_den_in = DIVISOR_AVG;
         end
         cha_pkg::SEL_SCL_X: begin
            op_num = num_x; op_scaled = 1'b1; op_den_in = span_x[DW-1:0];
         end
         cha_pkg::SEL_SCL_Y: begin
            op_num = num_y; op_scaled = 1'b1; op_den_in = span_y[DW-1:0];
         end
         default: begin
            op_num = tot_x_ff; op_scaled = 1'b0; op_den_in = DIVISOR_AVG;
         end
      endcase
      op_abs    = op_num[SW-1] ? -op_num : op_num;
      op_neg_in = op_num[SW-1];
      op_mag_in = op_scaled ? {op_abs[MW-1:0], {QF{1'b0}}} : VW'(op_abs[MW-1:0]);
   end

   // averages by reciprocal multiplication, scaled pair by the divider
   always_comb begin
      div_go      = cmd.div_start &&
                    ((cmd.sel == cha_pkg::SEL_SCL_X) || (cmd.sel == cha_pkg::SEL_SCL_Y));
      rcp_done_in = cmd.div_start && !div_go;
      rcp_prod    = (MW+RW)'(op_mag_ff[MW-1:0]) * (MW+RW)'(RECIP);
      rcp_quo_in  = rcp_prod[RS+QW-1:RS];
      quo_done    = div_done || rcp_done_ff;
      quo         = rcp_done_ff ? rcp_quo_ff : div_quo;
   end

   cha_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (op_mag_ff),
      .divisor  (op_den_ff),
      .done     (div_done),
      .quotient (div_quo),
      .ovf      (div_ovf)
   );

   // quotient sign and saturation
   always_comb begin
      neg_quo = -quo;
      avg_val = op_neg_ff ? neg_quo[DW-1:0] : quo[DW-1:0];
      if (op_neg_ff) begin
         scl_val = (div_ovf || quo > cha_pkg::Q_LIM_NEG) ? cha_pkg::Q_SAT_NEG
                                                         : neg_quo[DW-1:0];
      end else begin
         scl_val = (div_ovf || quo > cha_pkg::Q_LIM_POS) ? cha_pkg::Q_SAT_POS
                                                         : quo[DW-1:0];
      end
      avg_x_in = avg_x_ff;
      avg_y_in = avg_y_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      if (quo_done) begin
         case (cmd.sel)
            cha_pkg::SEL_AVG_X: avg_x_in = avg_val;
            cha_pkg::SEL_AVG_Y: avg_y_in = avg_val;
            cha_pkg::SEL_SCL_X: cx_in    = scl_val;
            cha_pkg::SEL_SCL_Y: cy_in    = scl_val;
            default: ;
         endcase
      end
   end

   // vectoring
   always_comb begin
      cx_w    = CW'(cx_ff);
      cy_w    = CW'(cy_ff);
      xs      = x_ff >>> cmd.step;
      ys      = y_ff >>> cmd.step;
      atan_s  = cha_pkg::atan_angle(cmd.step);
      x_in    = x_ff;
      y_in    = y_ff;
      ang_in  = ang_ff;
      zero_in = zero_ff;
      if (cmd.rot) begin
         zero_in = (cx_ff == '0) && (cy_ff == '0);
         if (cx_ff[DW-1]) begin
            if (!cy_ff[DW-1]) begin
               x_in = cy_w; y_in = -cx_w; ang_in = cha_pkg::DEG90;
            end else begin
               x_in = -cy_w; y_in = cx_w; ang_in = -cha_pkg::DEG90;
            end
         end else begin
            x_in = cx_w; y_in = cy_w; ang_in = '0;
         end
      end else if (cmd.cord) begin
         if (!y_ff[CW-1]) begin
            x_in = x_ff + ys; y_in = y_ff - xs; ang_in = ang_ff + atan_s;
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs; ang_in = ang_ff - atan_s;
         end
      end
   end

   // round and wrap
   always_comb begin
      ang_sum = ang_ff + cha_pkg::ROUND_HALF;
      ang_rnd = ang_sum >>> cha_pkg::RND_SHIFT;
      hd0     = ang_rnd[WW-1:0];
      hd1     = hd0[WW-1] ? hd0 + cha_pkg::FULL_TURN : hd0;
      hd2     = (hd1 >= cha_pkg::FULL_TURN) ? hd1 - cha_pkg::FULL_TURN : hd1;
      head_in = cmd.fin ? hd2[HW-1:0] : head_ff;
   end

   // result register
   always_comb begin
      ravg_x_in = ravg_x_ff;
      ravg_y_in = ravg_y_ff;
      rz_in     = rz_ff;
      rhead_in  = rhead_ff;
      rerr_in   = rerr_ff;
      if (cmd.out_load) begin
         ravg_x_in = avg_x_ff;
         ravg_y_in = avg_y_ff;
         rz_in     = zlat_ff;
         rhead_in  = (cal_err || zero_ff) ? '0 : head_ff;
         rerr_in   = cal_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff    <= cha_pkg::CAL_MIN_RST;
         max_x_ff    <= cha_pkg::CAL_MAX_RST;
         min_y_ff    <= cha_pkg::CAL_MIN_RST;
         max_y_ff    <= cha_pkg::CAL_MAX_RST;
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         rcp_done_ff <= 1'b0;
      end else begin
         min_x_ff    <= min_x_in;
         max_x_ff    <= max_x_in;
         min_y_ff    <= min_y_in;
         max_y_ff    <= max_y_in;
         sum_x_ff    <= sum_x_in;
         sum_y_ff    <= sum_y_in;
         rcp_done_ff <= rcp_done_in;
      end
   end

   always_ff @(posedge clock) begin
      tot_x_ff  <= tot_x_in;
      tot_y_ff  <= tot_y_in;
      zlat_ff   <= zlat_in;
      if (cmd.load_op) begin
         op_mag_ff <= op_mag_in;
         op_neg_ff <= op_neg_in;
         op_den_ff <= op_den_in;
      end
      rcp_quo_ff <= rcp_quo_in;
      avg_x_ff  <= avg_x_in;
      avg_y_ff  <= avg_y_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      ang_ff    <= ang_in;
      zero_ff   <= zero_in;
      head_ff   <= head_in;
      ravg_x_ff <= ravg_x_in;
      ravg_y_ff <= ravg_y_in;
      rz_ff     <= rz_in;
      rhead_ff  <= rhead_in;
      rerr_ff   <= rerr_in;
   end

   assign stat.div_done = quo_done;
   assign stat.cal_err  = cal_err;
   assign rsp_avg_x     = ravg_x_ff;
   assign rsp_avg_y     = ravg_y_ff;
   assign rsp_last_z    = rz_ff;
   assign rsp_heading   = rhead_ff;
   assign rsp_cal_error = rerr_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/cha_ctrl.sv -----
`default_nettype none

module cha_ctrl #(
   parameter int SAMPLES_AVERAGED = cha_pkg::SAMPLES_AVERAGED_DEF,
   parameter int CORDIC_STEPS     = cha_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire cha_pkg::stat_type   stat,
   output cha_pkg::cmd_type         cmd
);

   localparam int NW = cha_pkg::CNT_W;
   localparam int TW = cha_pkg::STEP_W;
   localparam int STEPS_RUN =
      (CORDIC_STEPS < cha_pkg::ATAN_LEN) ? CORDIC_STEPS : cha_pkg::ATAN_LEN;
   localparam logic [NW-1:0] LAST_CNT  = NW'(SAMPLES_AVERAGED - 1);
   localparam logic [TW-1:0] LAST_STEP = TW'(STEPS_RUN - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_START,
      S_DWAIT,
      S_ROT,
      S_CORD,
      S_FIN,
      S_OUT
   } state_type;

   state_type         state_ff;
   logic [NW-1:0]     count_ff;
   logic [TW-1:0]     step_ff;
   cha_pkg::sel_type  sel_ff;
   logic              rsp_valid_ff;
   logic              accept;
   logic              final_req;

   always_comb begin
      accept    = req_valid && (state_ff == S_IDLE);
      final_req = (count_ff == LAST_CNT);
      cmd.acc       = accept && !final_req;
      cmd.last      = accept && final_req;
      cmd.load_op   = (state_ff == S_LOAD);
      cmd.div_start = (state_ff == S_START);
      cmd.sel       = sel_ff;
      cmd.rot       = (state_ff == S_ROT);
      cmd.cord      = (state_ff == S_CORD);
      cmd.step      = step_ff;
      cmd.fin       = (state_ff == S_FIN);
      cmd.out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         sel_ff       <= cha_pkg::SEL_AVG_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (final_req) begin
                     count_ff <= '0;
                     sel_ff   <= cha_pkg::SEL_AVG_X;
                     state_ff <= S_LOAD;
                  end else begin
                     count_ff <= count_ff + NW'(1);
                  end
               end
            end
            S_LOAD: state_ff <= S_START;
            S_START: state_ff <= S_DWAIT;
            S_DWAIT: begin
               if (stat.div_done) begin
                  case (sel_ff)
                     cha_pkg::SEL_AVG_X: begin
                        sel_ff   <= cha_pkg::SEL_AVG_Y;
                        state_ff <= S_LOAD;
                     end
                     cha_pkg::SEL_AVG_Y: begin
                        if (stat.cal_err) begin
                           state_ff <= S_OUT;
                        end else begin
                           sel_ff   <= cha_pkg::SEL_SCL_X;
                           state_ff <= S_LOAD;
                        end
                     end
                     cha_pkg::SEL_SCL_X: begin
                        sel_ff   <= cha_pkg::SEL_SCL_Y;
                        state_ff <= S_LOAD;
                     end
                     default: state_ff <= S_ROT;
                  endcase
               end
            end
            S_ROT: begin
               step_ff  <= '0;
               state_ff <= S_CORD;
            end
            S_CORD: begin
               if (step_ff == LAST_STEP) begin
                  state_ff <= S_FIN;
               end else begin
                  step_ff <= step_ff + TW'(1);
               end
            end
            S_FIN: state_ff <= S_OUT;
            S_OUT: begin
               if (cmd.out_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/compass_heading_averager.sv -----
`default_nettype none
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_mag_x, req_mag_y, req_mag_z
// rsp       out        rsp_valid/rsp_ready    rsp_avg_x, rsp_avg_y, rsp_last_z,
//                                             rsp_heading, rsp_cal_error
// csr       in         csr_we                 csr_index, csr_wdata
//
// A request that does not close a group is added to the sums; the input stays ready.
// A closing request holds the input while two reciprocal passes form the averages, two passes
// of the 17-step divider form the scaled pair, and rotation, vectoring steps, rounding and
// response load follow.
// With invalid calibration only the averages are formed.
// Reset clears sums and sample count and restores calibration defaults; no clearing pass.
// A waiting response does not stall new requests until the next group closes.

module compass_heading_averager #(
   parameter int SAMPLES_AVERAGED = cha_pkg::SAMPLES_AVERAGED_DEF,
   parameter int CORDIC_STEPS     = cha_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [cha_pkg::DATA_W-1:0]    req_mag_x,
   input  wire logic signed [cha_pkg::DATA_W-1:0]    req_mag_y,
   input  wire logic signed [cha_pkg::DATA_W-1:0]    req_mag_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [cha_pkg::DATA_W-1:0]         rsp_avg_x,
   output logic signed [cha_pkg::DATA_W-1:0]         rsp_avg_y,
   output logic signed [cha_pkg::DATA_W-1:0]         rsp_last_z,
   output logic [cha_pkg::HEAD_W-1:0]                rsp_heading,
   output logic                                      rsp_cal_error,
   input  wire logic                                 csr_we,
   input  wire logic [cha_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [cha_pkg::DATA_W-1:0]           csr_wdata
);

   cha_pkg::cmd_type  cmd;
   cha_pkg::stat_type stat;

   cha_ctrl #(
      .SAMPLES_AVERAGED (SAMPLES_AVERAGED),
      .CORDIC_STEPS     (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cha_dp #(
      .SAMPLES_AVERAGED (SAMPLES_AVERAGED)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_mag_x     (req_mag_x),
      .req_mag_y     (req_mag_y),
      .req_mag_z     (req_mag_z),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_avg_x     (rsp_avg_x),
      .rsp_avg_y     (rsp_avg_y),
      .rsp_last_z    (rsp_last_z),
      .rsp_heading   (rsp_heading),
      .rsp_cal_error (rsp_cal_error)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/cha_checker.sv -----
`default_nettype none

module cha_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [cha_pkg::HEAD_W-1:0]  rsp_heading,
   input wire logic                        rsp_cal_error
);

   localparam logic [cha_pkg::HEAD_W-1:0] HEAD_LIMIT = 13'd5760;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading))
      else $error("response dropped or changed while stalled");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading < HEAD_LIMIT)
      else $error("heading outside one turn");

   a_err_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cal_error |-> rsp_heading == '0)
      else $error("heading given with invalid calibration");

   a_busy_before_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a computing pass");

endmodule

bind compass_heading_averager cha_checker u_cha_checker (.*);

`default_nettype wire
